// File: hw/rtl/ecc_pkg.sv
package ecc_pkg;

  // Pipeline depth: stage 0 takes the item, stage NumStages-1 presents it.
  localparam int unsigned NumStages = 7;

  typedef struct packed {
    logic [NumStages-1:0] load;  // stage register takes the item from the stage before
  } pipe_ctl_t;

  // Command codes.
  localparam logic CmdSplit = 1'b0;
  localparam logic CmdJoin  = 1'b1;

  // Calendar constants.
  localparam logic [31:0] EpochY2k    = 32'd946684800;
  localparam logic [16:0] DaySecs     = 17'd86400;
  localparam logic [10:0] FourYears   = 11'd1461;
  localparam logic [11:0] BaseYear    = 12'd1970;
  localparam logic [11:0] JoinYear    = 12'd2000;
  localparam logic [11:0] JoinYearMax = 12'd2099;
  localparam logic [6:0]  JoinYearSpan = 7'd99;
  localparam logic [8:0]  FebLastDoy  = 9'd58;
  localparam logic signed [17:0] SecPerHour = 18'sd3600;

  // Reciprocals for division by a constant: q = (x * R) >> S, exact over
  // the operand range used here.
  localparam logic [25:0] RecipDay  = 26'd50903317;  // (x >> 7) / 675, S = 35
  localparam logic [18:0] RecipYear = 19'd367469;    // x / 1461, S = 29
  localparam logic [17:0] RecipMin  = 18'd139811;    // x / 60 for x < 2^17, S = 23
  localparam logic [11:0] RecipHour = 12'd2185;      // x / 60 for x < 2^11, S = 17
  localparam logic [13:0] RecipMon  = 14'd11429;     // x / 367 for x < 2^13, S = 22

  // Length of a month (1..12) in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of a month (1..12) in a common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Start of a month under the 367/12 approximation: (q * 367 + 5) / 12.
  function automatic logic [8:0] month_start(input logic [3:0] q);
    logic [8:0] d;
    unique case (q)
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd183;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd336;
      4'd12:   d = 9'd367;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/ecc_ctrl.sv
module ecc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              command,
  output ecc_pkg::pipe_ctl_t ctl,
  output logic              cmd_last
);

  logic [ecc_pkg::NumStages-1:0] vld;
  logic [ecc_pkg::NumStages-1:0] cmd;
  logic [ecc_pkg::NumStages-1:0] rdy;

  // A stage can take an item when empty or when its own item moves on.
  always_comb begin
    rdy[ecc_pkg::NumStages-1] = !vld[ecc_pkg::NumStages-1] || !out_stall;
    for (int i = ecc_pkg::NumStages - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < ecc_pkg::NumStages; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cmd[0] <= command;
    end
    for (int i = 1; i < ecc_pkg::NumStages; i++) begin
      if (rdy[i]) begin
        cmd[i] <= cmd[i-1];
      end
    end
  end

  assign ctl.load  = rdy;
  assign in_stall  = !rdy[0];
  assign out_valid = vld[ecc_pkg::NumStages-1];
  assign cmd_last  = cmd[ecc_pkg::NumStages-1];

endmodule

// File: hw/rtl/ecc_split.sv
module ecc_split (
  input  logic               clk,
  input  ecc_pkg::pipe_ctl_t ctl,
  input  logic [31:0]        epoch_seconds,
  input  logic [31:0]        off_secs,
  output logic [31:0]        epoch,
  output logic [11:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);

  // stage 0
  logic [31:0] ep0, t0;
  // stage 1
  logic [31:0] ep1, t1;
  logic [15:0] days1;
  // stage 2
  logic [31:0] ep2;
  logic [15:0] days2;
  logic [16:0] secs2;
  logic [7:0]  years2;
  // stage 3
  logic [31:0] ep3;
  logic [16:0] secs3;
  logic [10:0] mins3;
  logic [8:0]  doy3;
  logic [11:0] year3;
  logic        leap3;
  // stage 4
  logic [31:0] ep4;
  logic [10:0] mins4;
  logic [5:0]  sec4;
  logic [4:0]  hour4;
  logic [8:0]  doy4;
  logic [11:0] year4;
  // stage 5
  logic [31:0] ep5;
  logic [5:0]  sec5, min5;
  logic [4:0]  hour5;
  logic [8:0]  doy5;
  logic [3:0]  q5;
  logic [11:0] year5;

  logic [50:0] days_prod;
  logic [32:0] day_secs;
  logic [31:0] secs_full;
  logic [17:0] years_x;
  logic [36:0] years_prod;
  logic [34:0] mins_prod;
  logic [18:0] base_prod;
  logic [15:0] doy_full;
  logic [16:0] min_secs;
  logic [16:0] sec_full;
  logic [22:0] hour_prod;
  logic [8:0]  doy_thresh;
  logic [8:0]  doy_adj;
  logic [10:0] hr_mins;
  logic [10:0] min_full;
  logic [12:0] mon_x;
  logic [26:0] mon_prod;
  logic [8:0]  day_full;

  assign days_prod  = t0[31:7] * ecc_pkg::RecipDay;
  assign day_secs   = days1 * ecc_pkg::DaySecs;
  assign secs_full  = t1 - day_secs[31:0];
  assign years_x    = {days1, 2'b10};
  assign years_prod = years_x * ecc_pkg::RecipYear;
  assign mins_prod  = secs2 * ecc_pkg::RecipMin;
  assign base_prod  = years2 * ecc_pkg::FourYears + 19'd1;
  assign doy_full   = days2 - base_prod[17:2];
  assign min_secs   = mins3 * 17'd60;
  assign sec_full   = secs3 - min_secs;
  assign hour_prod  = mins3 * ecc_pkg::RecipHour;
  assign doy_thresh = ecc_pkg::FebLastDoy + {8'd0, leap3};
  assign doy_adj    = leap3 ? doy3 + 9'd1 : doy3 + 9'd2;
  assign hr_mins    = hour4 * 11'd60;
  assign min_full   = mins4 - hr_mins;
  assign mon_x      = doy4 * 13'd12 + 13'd6;
  assign mon_prod   = mon_x * ecc_pkg::RecipMon;
  assign day_full   = doy5 + 9'd1 - ecc_pkg::month_start(q5);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      ep0 <= epoch_seconds;
      t0  <= epoch_seconds + off_secs;
    end
    if (ctl.load[1]) begin
      ep1   <= ep0;
      t1    <= t0;
      days1 <= days_prod[50:35];
    end
    if (ctl.load[2]) begin
      ep2    <= ep1;
      days2  <= days1;
      secs2  <= secs_full[16:0];
      years2 <= years_prod[36:29];
    end
    if (ctl.load[3]) begin
      ep3   <= ep2;
      secs3 <= secs2;
      mins3 <= mins_prod[33:23];
      doy3  <= doy_full[8:0];
      year3 <= {4'd0, years2} + ecc_pkg::BaseYear;
      leap3 <= (years2[1:0] == 2'd2);
    end
    if (ctl.load[4]) begin
      ep4   <= ep3;
      mins4 <= mins3;
      sec4  <= sec_full[5:0];
      hour4 <= hour_prod[21:17];
      doy4  <= (doy3 > doy_thresh) ? doy_adj : doy3;
      year4 <= year3;
    end
    if (ctl.load[5]) begin
      ep5   <= ep4;
      sec5  <= sec4;
      min5  <= min_full[5:0];
      hour5 <= hour4;
      doy5  <= doy4;
      q5    <= mon_prod[25:22];
      year5 <= year4;
    end
    if (ctl.load[6]) begin
      epoch  <= ep5;
      year   <= year5;
      month  <= q5 + 4'd1;
      day    <= day_full[4:0];
      hour   <= hour5;
      minute <= min5;
      second <= sec5;
    end
  end

endmodule

// File: hw/rtl/ecc_join.sv
module ecc_join (
  input  logic               clk,
  input  ecc_pkg::pipe_ctl_t ctl,
  input  logic [11:0]        year_in,
  input  logic [7:0]         month_in,
  input  logic [7:0]         day_in,
  input  logic [7:0]         hour_in,
  input  logic [7:0]         minute_in,
  input  logic [7:0]         second_in,
  input  logic [31:0]        join_bias,
  output logic [31:0]        epoch,
  output logic [11:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);

  // stage 0: clamped fields; the day is clamped in stage 1
  logic [6:0]  yo0;
  logic [3:0]  mon0;
  logic [7:0]  dayr0;
  logic [4:0]  hour0;
  logic [5:0]  min0, sec0;
  // stage 1
  logic [11:0] year1;
  logic [3:0]  mon1;
  logic [4:0]  day1, hour1;
  logic [5:0]  min1, sec1;
  logic [8:0]  cum1;
  logic [15:0] ydays1;
  // stage 2
  logic [11:0] year2;
  logic [3:0]  mon2;
  logic [4:0]  day2, hour2;
  logic [5:0]  min2, sec2;
  logic [15:0] dc2;
  // stage 3
  logic [11:0] year3;
  logic [3:0]  mon3;
  logic [4:0]  day3, hour3;
  logic [5:0]  min3, sec3;
  logic [19:0] hm3;
  // stage 4
  logic [11:0] year4;
  logic [3:0]  mon4;
  logic [4:0]  day4, hour4;
  logic [5:0]  min4, sec4;
  logic [25:0] hms4;
  // stage 5
  logic [11:0] year5;
  logic [3:0]  mon5;
  logic [4:0]  day5, hour5;
  logic [5:0]  min5, sec5;
  logic [31:0] s5;

  logic [11:0] yo_full;
  logic        leap;
  logic [4:0]  mlen;
  logic [7:0]  yo_round;

  assign yo_full  = year_in - ecc_pkg::JoinYear;
  assign leap     = (yo0[1:0] == 2'd0);
  assign mlen     = ecc_pkg::month_len(mon0) + {4'd0, (mon0 == 4'd2) && leap};
  assign yo_round = ({1'b0, yo0} + 8'd3) >> 2;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      if (year_in < ecc_pkg::JoinYear) begin
        yo0 <= 7'd0;
      end else if (year_in > ecc_pkg::JoinYearMax) begin
        yo0 <= ecc_pkg::JoinYearSpan;
      end else begin
        yo0 <= yo_full[6:0];
      end
      if (month_in == 8'd0) begin
        mon0 <= 4'd1;
      end else if (month_in > 8'd12) begin
        mon0 <= 4'd12;
      end else begin
        mon0 <= month_in[3:0];
      end
      dayr0 <= day_in;
      hour0 <= (hour_in > 8'd23) ? 5'd23 : hour_in[4:0];
      min0  <= (minute_in > 8'd59) ? 6'd59 : minute_in[5:0];
      sec0  <= (second_in > 8'd59) ? 6'd59 : second_in[5:0];
    end
    if (ctl.load[1]) begin
      year1 <= {5'd0, yo0} + ecc_pkg::JoinYear;
      mon1  <= mon0;
      if (dayr0 == 8'd0) begin
        day1 <= 5'd1;
      end else if (dayr0 > {3'd0, mlen}) begin
        day1 <= mlen;
      end else begin
        day1 <= dayr0[4:0];
      end
      hour1  <= hour0;
      min1   <= min0;
      sec1   <= sec0;
      cum1   <= ecc_pkg::days_before(mon0) + {8'd0, (mon0 > 4'd2) && leap};
      ydays1 <= yo0 * 16'd365 + {8'd0, yo_round};
    end
    if (ctl.load[2]) begin
      year2 <= year1;
      mon2  <= mon1;
      day2  <= day1;
      hour2 <= hour1;
      min2  <= min1;
      sec2  <= sec1;
      dc2   <= ydays1 + {7'd0, cum1} + {11'd0, day1} - 16'd1;
    end
    if (ctl.load[3]) begin
      year3 <= year2;
      mon3  <= mon2;
      day3  <= day2;
      hour3 <= hour2;
      min3  <= min2;
      sec3  <= sec2;
      hm3   <= dc2 * 20'd24 + {15'd0, hour2};
    end
    if (ctl.load[4]) begin
      year4 <= year3;
      mon4  <= mon3;
      day4  <= day3;
      hour4 <= hour3;
      min4  <= min3;
      sec4  <= sec3;
      hms4  <= hm3 * 26'd60 + {20'd0, min3};
    end
    if (ctl.load[5]) begin
      year5 <= year4;
      mon5  <= mon4;
      day5  <= day4;
      hour5 <= hour4;
      min5  <= min4;
      sec5  <= sec4;
      s5    <= hms4 * 32'd60 + {26'd0, sec4};
    end
    if (ctl.load[6]) begin
      epoch  <= s5 + join_bias;
      year   <= year5;
      month  <= mon5;
      day    <= day5;
      hour   <= hour5;
      minute <= min5;
      second <= sec5;
    end
  end

endmodule

// File: hw/rtl/epoch_calendar_converter.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  command, epoch_seconds, year_in .. second_in
// result    out        out_valid / out_stall epoch_out, year_out .. second_out
// config    in         cfg_we               cfg_wdata (utc_offset_hours, signed)
//
// Seven register stages; an item enters every cycle while in_stall is low,
// and its result leaves the last stage. The depth is set by the split path's
// chain of reciprocal multiplies (days, years, minutes, hours, month).
// Synchronous reset empties the pipeline and sets the offset to zero.
// A stall on the result side holds the last stage; earlier stages keep
// moving into empty slots, so in_stall rises only when every stage is full.
module epoch_calendar_converter (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] epoch_seconds,
  input  logic [11:0] year_in,
  input  logic [7:0]  month_in,
  input  logic [7:0]  day_in,
  input  logic [7:0]  hour_in,
  input  logic [7:0]  minute_in,
  input  logic [7:0]  second_in,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] epoch_out,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);

  // Hold the offset in the two forms the datapaths use: seconds to add
  // before a split, and the full bias to add after a join.
  logic [31:0] off_secs, off_secs_next;
  logic [31:0] join_bias, join_bias_next;
  logic signed [17:0] off_hours_ext;
  logic signed [17:0] off_prod;

  assign off_hours_ext  = 18'($signed(cfg_wdata));
  assign off_prod       = off_hours_ext * ecc_pkg::SecPerHour;
  assign off_secs_next  = 32'(off_prod);
  assign join_bias_next = ecc_pkg::EpochY2k - off_secs_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_secs  <= '0;
      join_bias <= ecc_pkg::EpochY2k;
    end else if (cfg_we) begin
      off_secs  <= off_secs_next;
      join_bias <= join_bias_next;
    end
  end

  ecc_pkg::pipe_ctl_t ctl;
  logic               cmd_last;

  // Track valid and command per stage; drive the stage load enables.
  ecc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .command   (command),
    .ctl       (ctl),
    .cmd_last  (cmd_last)
  );

  logic [31:0] sp_epoch, jn_epoch;
  logic [11:0] sp_year, jn_year;
  logic [3:0]  sp_month, jn_month;
  logic [4:0]  sp_day, jn_day;
  logic [4:0]  sp_hour, jn_hour;
  logic [5:0]  sp_minute, jn_minute;
  logic [5:0]  sp_second, jn_second;

  // Both paths run on every item; the command picks the result at the end.
  ecc_split u_split (
    .clk           (clk),
    .ctl           (ctl),
    .epoch_seconds (epoch_seconds),
    .off_secs      (off_secs),
    .epoch         (sp_epoch),
    .year          (sp_year),
    .month         (sp_month),
    .day           (sp_day),
    .hour          (sp_hour),
    .minute        (sp_minute),
    .second        (sp_second)
  );

  ecc_join u_join (
    .clk       (clk),
    .ctl       (ctl),
    .year_in   (year_in),
    .month_in  (month_in),
    .day_in    (day_in),
    .hour_in   (hour_in),
    .minute_in (minute_in),
    .second_in (second_in),
    .join_bias (join_bias),
    .epoch     (jn_epoch),
    .year      (jn_year),
    .month     (jn_month),
    .day       (jn_day),
    .hour      (jn_hour),
    .minute    (jn_minute),
    .second    (jn_second)
  );

  always_comb begin
    unique case (cmd_last)
      ecc_pkg::CmdJoin: begin
        epoch_out  = jn_epoch;
        year_out   = jn_year;
        month_out  = jn_month;
        day_out    = jn_day;
        hour_out   = jn_hour;
        minute_out = jn_minute;
        second_out = jn_second;
      end
      default: begin
        epoch_out  = sp_epoch;
        year_out   = sp_year;
        month_out  = sp_month;
        day_out    = sp_day;
        hour_out   = sp_hour;
        minute_out = sp_minute;
        second_out = sp_second;
      end
    endcase
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // One conversion request as it sits on the input ports.
  typedef struct {
    logic        cmd;
    bit   [31:0] ep;
    bit   [11:0] yr;
    bit   [7:0]  mon;
    bit   [7:0]  dy;
    bit   [7:0]  hr;
    bit   [7:0]  mi;
    bit   [7:0]  sc;
  } conv_item_t;

  // One converted date/time as it leaves the result ports.
  typedef struct {
    bit [31:0] ep;
    bit [11:0] yr;
    bit [3:0]  mon;
    bit [4:0]  dy;
    bit [4:0]  hr;
    bit [5:0]  mi;
    bit [5:0]  sc;
  } cal_result_t;

  localparam int WatchdogLimit = 2000;
  localparam int RandomPerPhase = 100;
  localparam int NumPhases = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = ecc_pkg::CmdSplit;
  logic [31:0] epoch_seconds = '0;
  logic [11:0] year_in = '0;
  logic [7:0]  month_in = '0;
  logic [7:0]  day_in = '0;
  logic [7:0]  hour_in = '0;
  logic [7:0]  minute_in = '0;
  logic [7:0]  second_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] epoch_out;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  // Items waiting to be sent, and converted dates waiting to come back.
  conv_item_t  pending_items[$];
  conv_item_t  cur_item;
  cal_result_t expected_dates[$];

  // Local copy of the offset register, in whole hours.
  logic signed [4:0] local_offset = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  int month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  // Offset for each phase; the last one is drawn at random.
  int phase_offset [NumPhases] = '{0, 14, -12, 15, -16, 0};

  epoch_calendar_converter i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .epoch_seconds (epoch_seconds),
    .year_in       (year_in),
    .month_in      (month_in),
    .day_in        (day_in),
    .hour_in       (hour_in),
    .minute_in     (minute_in),
    .second_in     (second_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_out     (epoch_out),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out)
  );

  always #5 clk = ~clk;

  function automatic bit [31:0] clamp_to(bit [31:0] v, bit [31:0] lo, bit [31:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Compute the converted date for one item under the given hour offset.
  function automatic cal_result_t convert_item(conv_item_t it, logic signed [4:0] off);
    cal_result_t r;
    int          shift_s;
    bit [31:0]   shift, t, days, secs, mins, years, yr, mon, dy, hr, mi, sc, mlen, yo;
    bit          leap;
    int          m;
    shift_s = off * 3600;
    shift = shift_s;
    if (it.cmd == ecc_pkg::CmdSplit) begin
      // Shift into local time, then peel off days and the time of day.
      t = it.ep + shift;
      days = t / 86400;
      secs = t % 86400;
      mins = secs / 60;
      // Four-year cycle of 1461 days; every fourth year counts as leap.
      years = (days * 4 + 2) / 1461;
      yr = years + 1970;
      leap = (yr[1:0] == 2'b00);
      days = days - (years * 1461 + 1) / 4;
      // Skip the missing February days so the 367/12 month rule lines up.
      if (days > 58 + leap) days = days + (leap ? 1 : 2);
      mon = (days * 12 + 6) / 367 + 1;
      dy = days + 1 - ((mon - 1) * 367 + 5) / 12;
      hr = mins / 60;
      mi = mins % 60;
      sc = secs % 60;
      r.ep = it.ep;
    end else begin
      // Clamp every field, the day against the clamped month.
      yr = clamp_to(32'(it.yr), 2000, 2099);
      mon = clamp_to(32'(it.mon), 1, 12);
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      mlen = month_days[mon - 1] + ((mon == 2 && leap) ? 1 : 0);
      dy = clamp_to(32'(it.dy), 1, mlen);
      hr = clamp_to(32'(it.hr), 0, 23);
      mi = clamp_to(32'(it.mi), 0, 59);
      sc = clamp_to(32'(it.sc), 0, 59);
      // Count days since 2000-01-01.
      days = dy;
      for (m = 1; m < mon; m++) days = days + month_days[m - 1];
      if (mon > 2 && leap) days = days + 1;
      yo = yr - 2000;
      days = days + 365 * yo + (yo + 3) / 4 - 1;
      t = ((days * 24 + hr) * 60 + mi) * 60 + sc;
      r.ep = t - shift + 32'd946684800;
    end
    r.yr = yr[11:0];
    r.mon = mon[3:0];
    r.dy = dy[4:0];
    r.hr = hr[4:0];
    r.mi = mi[5:0];
    r.sc = sc[5:0];
    return r;
  endfunction

  // Rough epoch of day doy of year y; good enough to aim near boundaries.
  function automatic bit [31:0] epoch_at(int y, int doy, int s);
    return (365 * (y - 1970) + (y - 1969) / 4 + doy) * 86400 + s;
  endfunction

  function automatic conv_item_t split_item(bit [31:0] ep);
    conv_item_t it;
    it = '{ecc_pkg::CmdSplit, ep, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    return it;
  endfunction

  function automatic conv_item_t join_item(int y, int mo, int d, int h, int mn, int s);
    conv_item_t it;
    it = '{ecc_pkg::CmdJoin, 32'd0, y[11:0], mo[7:0], d[7:0], h[7:0], mn[7:0], s[7:0]};
    return it;
  endfunction

  // Mostly near the legal range, sometimes any byte at all.
  function automatic bit [7:0] near_range(int lo, int hi);
    return ($urandom_range(99) < 70) ? 8'($urandom_range(hi, lo)) : 8'($urandom);
  endfunction

  function automatic conv_item_t random_item();
    conv_item_t it;
    int         y, doy, s, shift_s;
    it.cmd = 1'($urandom_range(1));
    it.ep = $urandom;
    it.yr = 12'($urandom);
    it.mon = 8'($urandom);
    it.dy = 8'($urandom);
    it.hr = 8'($urandom);
    it.mi = 8'($urandom);
    it.sc = 8'($urandom);
    if (it.cmd == ecc_pkg::CmdSplit) begin
      if ($urandom_range(1)) begin
        // Aim at year, February and March edges in local time.
        y = $urandom_range(2106, 1970);
        case ($urandom_range(5))
          0: doy = 0;
          1: doy = 58;
          2: doy = 59;
          3: doy = 60;
          4: doy = $urandom_range(365, 364);
          default: doy = $urandom_range(365);
        endcase
        case ($urandom_range(2))
          0: s = 0;
          1: s = 86399;
          default: s = $urandom_range(86399);
        endcase
        shift_s = local_offset * 3600;
        it.ep = epoch_at(y, doy, s) - shift_s;
      end
    end else begin
      case ($urandom_range(3))
        0: it.yr = 12'($urandom);
        1: it.yr = 12'($urandom_range(2110, 1990));
        2: it.yr = 12'($urandom_range(2099, 2000));
        default: it.yr = ($urandom_range(1)) ? 12'($urandom_range(2000, 1999))
                                              : 12'($urandom_range(2100, 2099));
      endcase
      it.mon = near_range(0, 13);
      it.dy = near_range(0, 32);
      it.hr = near_range(0, 25);
      it.mi = near_range(0, 61);
      it.sc = near_range(0, 61);
    end
    return it;
  endfunction

  function automatic void check_field(string name, bit [31:0] want, bit [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Write the offset register while the pipeline is empty.
  task automatic write_offset(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    local_offset = v[4:0];
  endtask

  // Hold until every item has gone in and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_dates.size() != 0);
  endtask

  // Driver: predict on acceptance, hold a stalled item, otherwise maybe idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_dates.push_back(convert_item(cur_item, local_offset));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          command <= cur_item.cmd;
          epoch_seconds <= cur_item.ep;
          year_in <= cur_item.yr;
          month_in <= cur_item.mon;
          day_in <= cur_item.dy;
          hour_in <= cur_item.hr;
          minute_in <= cur_item.mi;
          second_in <= cur_item.sc;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    cal_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, epoch_out expected none actual %0d",
                 $time, epoch_out);
      end else begin
        want = expected_dates.pop_front();
        check_field("epoch_out", want.ep, epoch_out);
        check_field("year_out", 32'(want.yr), 32'(year_out));
        check_field("month_out", 32'(want.mon), 32'(month_out));
        check_field("day_out", 32'(want.dy), 32'(day_out));
        check_field("hour_out", 32'(want.hr), 32'(hour_out));
        check_field("minute_out", 32'(want.mi), 32'(minute_out));
        check_field("second_out", 32'(want.sc), 32'(second_out));
      end
    end
  end

  // Watchdog: end the run once nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    phase_offset[NumPhases - 1] = $urandom_range(26) - 12;
    for (ph = 0; ph < NumPhases; ph++) begin
      // Two phases per idling pattern: receiver-heavy gaps, sender-heavy gaps, none.
      case (ph / 2)
        0: begin
          send_idle_pct = 20;
          recv_stall_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_offset(phase_offset[ph]);
      // Offset wrap at both ends of the seconds range, in every setting.
      pending_items.push_back(split_item(32'd0));
      pending_items.push_back(split_item(32'hFFFF_FFFF));
      if (ph == 0) begin
        // Split: century start, leap days, year ends, and past 2099.
        pending_items.push_back(split_item(32'd946684800));
        pending_items.push_back(split_item(epoch_at(1972, 59, 0)));
        pending_items.push_back(split_item(epoch_at(1999, 364, 86399)));
        pending_items.push_back(split_item(epoch_at(2000, 59, 43200)));
        pending_items.push_back(split_item(epoch_at(2000, 60, 0)));
        pending_items.push_back(split_item(epoch_at(2100, 59, 0)));
        pending_items.push_back(split_item(epoch_at(2100, 60, 3661)));
        pending_items.push_back(split_item(epoch_at(2106, 37, 86399)));
        // Join: all-zero and all-ones fields, year saturation, day clamping.
        pending_items.push_back(join_item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(join_item(4095, 255, 255, 255, 255, 255));
        pending_items.push_back(join_item(1999, 1, 1, 0, 0, 0));
        pending_items.push_back(join_item(2100, 12, 31, 23, 59, 59));
        pending_items.push_back(join_item(2000, 1, 1, 0, 0, 0));
        pending_items.push_back(join_item(2099, 12, 31, 23, 59, 59));
        pending_items.push_back(join_item(2000, 2, 30, 12, 30, 30));
        pending_items.push_back(join_item(2099, 2, 29, 1, 2, 3));
        pending_items.push_back(join_item(2024, 4, 31, 24, 60, 60));
        pending_items.push_back(join_item(2050, 13, 0, 7, 8, 9));
      end
      repeat (RandomPerPhase) pending_items.push_back(random_item());
      wait_drained();
    end
    // Let any stray result show up before the verdict.
    repeat (ecc_pkg::NumStages + 4) @(posedge clk);
    if (errors == 0 && expected_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
